// File: rtl/core/ckvt_pkg.sv
// shared types and constants of the compacting key/quantity table
`default_nettype none

package ckvt_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_LIST   = 2'd3
  } ckvt_op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } ckvt_status_e;

  // which result the datapath builds into its output register
  typedef enum logic [2:0] {
    EMIT_INS_OK = 3'd0,
    EMIT_FULL   = 3'd1,
    EMIT_HIT    = 3'd2,
    EMIT_MISS   = 3'd3,
    EMIT_EMPTY  = 3'd4,
    EMIT_LIST   = 3'd5
  } ckvt_emit_e;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] item_key;
    logic signed [DATA_W-1:0] item_quantity;
  } ckvt_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] found_key;
    logic signed [DATA_W-1:0] found_quantity;
    logic                     last_result;
  } ckvt_out_t;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] quantity;
  } ckvt_entry_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       rd_issue;
    logic       ins_wr;
    logic       shift_wr;
    logic       cnt_dec;
    logic       emit;
    ckvt_emit_e emit_sel;
  } ckvt_cmd_t;

  // datapath to controller
  typedef struct packed {
    ckvt_op_e opcode;
    logic     full;
    logic     empty;
    logic     issue_ok;
    logic     cmp_vld;
    logic     match;
    logic     cmp_last;
  } ckvt_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/ckvt_dp.sv
// datapath: entry memory, fill count, scan pointers and result register
`default_nettype none

module ckvt_dp #(
  parameter int unsigned DEPTH = ckvt_pkg::DEPTH_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  ckvt_pkg::ckvt_in_t  in_item,
  input  ckvt_pkg::ckvt_cmd_t cmd,
  output ckvt_pkg::ckvt_stat_t stat,
  output logic               out_valid,
  output ckvt_pkg::ckvt_out_t out_item
);
  import ckvt_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ckvt_entry_t mem [DEPTH];

  ckvt_in_t    item_r;
  ckvt_entry_t rdata_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cmp_idx_r;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  ckvt_out_t     out_item_r, out_item_nxt;

  logic          issue_ok;
  logic          cmp_last;
  logic [AW-1:0] shift_addr;

  assign issue_ok   = idx_r < count_r;
  assign cmp_last   = (cmp_idx_r + CW'(1)) == count_r;
  assign shift_addr = AW'(cmp_idx_r - CW'(1));

  assign stat.opcode   = ckvt_op_e'(item_r.opcode);
  assign stat.full     = count_r == CW'(DEPTH);
  assign stat.empty    = count_r == '0;
  assign stat.issue_ok = issue_ok;
  assign stat.cmp_vld  = cmp_vld_r;
  assign stat.match    = rdata_r.key == item_r.item_key;
  assign stat.cmp_last = cmp_last;

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      mem[count_r[AW-1:0]] <= '{key: item_r.item_key, quantity: item_r.item_quantity};
    end else if (cmd.shift_wr) begin
      mem[shift_addr] <= rdata_r;
    end
    if (cmd.rd_issue) begin
      rdata_r <= mem[idx_r[AW-1:0]];
    end
  end

  always_comb begin
    idx_nxt     = idx_r;
    cmp_vld_nxt = cmd.rd_issue;
    count_nxt   = count_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.rd_issue) begin
      idx_nxt = idx_r + CW'(1);
    end
    if (cmd.ins_wr) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = cmd.emit;
    out_item_nxt  = '0;
    out_item_nxt.last_result = 1'b1;
    unique case (cmd.emit_sel)
      EMIT_INS_OK: begin
        out_item_nxt.status         = STAT_OK;
        out_item_nxt.position       = POS_W'(count_r);
        out_item_nxt.found_key      = item_r.item_key;
        out_item_nxt.found_quantity = item_r.item_quantity;
      end
      EMIT_FULL: out_item_nxt.status = STAT_FULL;
      EMIT_HIT: begin
        out_item_nxt.status         = STAT_OK;
        out_item_nxt.position       = POS_W'(cmp_idx_r);
        out_item_nxt.found_key      = rdata_r.key;
        out_item_nxt.found_quantity = rdata_r.quantity;
      end
      EMIT_MISS:  out_item_nxt.status = STAT_NOT_FOUND;
      EMIT_EMPTY: out_item_nxt.status = STAT_EMPTY;
      EMIT_LIST: begin
        out_item_nxt.status         = STAT_OK;
        out_item_nxt.position       = POS_W'(cmp_idx_r);
        out_item_nxt.found_key      = rdata_r.key;
        out_item_nxt.found_quantity = rdata_r.quantity;
        out_item_nxt.last_result    = cmp_last;
      end
      default: out_item_nxt.status = STAT_NOT_FOUND;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.rd_issue) begin
      cmp_idx_r <= idx_r;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: rtl/core/ckvt_ctrl.sv
// controller: sequences insert, scan, shift and list over the datapath
`default_nettype none

module ckvt_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  ckvt_pkg::ckvt_stat_t stat,
  output ckvt_pkg::ckvt_cmd_t  cmd
);
  import ckvt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT,
    S_LIST
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.opcode)
          OP_INSERT: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = stat.full ? EMIT_FULL : EMIT_INS_OK;
            cmd.ins_wr   = !stat.full;
            state_nxt    = S_IDLE;
          end
          OP_SEARCH, OP_DELETE: begin
            if (stat.empty) begin
              cmd.emit     = 1'b1;
              cmd.emit_sel = EMIT_MISS;
              state_nxt    = S_IDLE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          OP_LIST: begin
            if (stat.empty) begin
              cmd.emit     = 1'b1;
              cmd.emit_sel = EMIT_EMPTY;
              state_nxt    = S_IDLE;
            end else begin
              state_nxt = S_LIST;
            end
          end
        endcase
      end
      S_SCAN: begin
        cmd.rd_issue = stat.issue_ok;
        if (stat.cmp_vld) begin
          if (stat.match) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EMIT_HIT;
            state_nxt    = (stat.opcode == OP_DELETE) ? S_SHIFT : S_IDLE;
          end else if (stat.cmp_last) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EMIT_MISS;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_SHIFT: begin
        // read one ahead, write it one place down
        cmd.rd_issue = stat.issue_ok;
        cmd.shift_wr = stat.cmp_vld;
        if (!stat.cmp_vld && !stat.issue_ok) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_LIST: begin
        cmd.rd_issue = stat.issue_ok;
        if (stat.cmp_vld) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_LIST;
          if (stat.cmp_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

`default_nettype wire

// File: rtl/core/compacting_key_value_table_top.sv
// top level of the compacting key/quantity table
`default_nettype none

// insert: item loaded on accept; the dispatch state writes it and registers its result, busy only there
// search/delete: scan reads one entry per cycle from the entry memory; a hit, or a miss
//   at the last entry, is registered as the result
// delete then shifts the tail down one entry per cycle
// list: one result per cycle, first entry to last, the last one flagged by last_result
// synchronous active-low reset empties the table; results cannot be stalled by the receiver
module compacting_key_value_table_top #(
  parameter int unsigned DEPTH = ckvt_pkg::DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  // input channel: accepted when start is high and busy is low
  input  wire                 start,
  output logic                busy,
  input  ckvt_pkg::ckvt_in_t  in_item,
  // result channel: one item per out_valid cycle
  output logic                out_valid,
  output ckvt_pkg::ckvt_out_t out_item
);
  import ckvt_pkg::*;

  // command and status between the sequencer and the datapath
  ckvt_cmd_t  cmd;
  ckvt_stat_t stat;

  // sequencer: dispatch on opcode, then scan, shift or list
  ckvt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath: entry memory with one write and one registered read port,
  // the fill count and the result register
  ckvt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: verif/compacting_key_value_table_top_tb.sv
// self-checking testbench for the compacting key/quantity table top level
module compacting_key_value_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ckvt_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  // slowest item is a delete near the head of a full table, which shifts the whole tail,
  // plus the longest sender gap; a few hundred items fit well inside this
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 2 * DEPTH + 8;
  localparam int PRINT_CAP   = 40;

  // directed rows: a single item, or a run of inserts that fills the table
  typedef enum logic {ROW_ITEM, ROW_FILL} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    ckvt_op_e    op;
    logic [31:0] key;
    logic [31:0] qty;
    logic        fixed;   // expected result typed in the row
    ckvt_out_t   res;
  } stim_row_t;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  logic      busy;
  ckvt_in_t  in_item = '0;
  logic      out_valid;
  ckvt_out_t out_item;

  // private copy of the table, updated as each item is accepted
  logic [31:0] model_key [DEPTH];
  logic [31:0] model_qty [DEPTH];
  int          model_count = 0;

  ckvt_out_t   step_results [$];     // results of the item just accepted
  ckvt_out_t   pending_results [$];  // results still owed by the block
  stim_row_t   directed_plan [$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int cycle_count    = 0;
  int burst_left     = 0;

  compacting_key_value_table_top #(.DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [79:0] got,
                                 input logic [79:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch %s at result %0d: got %h expected %h", what, results_seen, got,
               want);
    mismatch_count++;
  endtask

  function automatic ckvt_out_t make_result(input ckvt_status_e st, input int pos,
                                            input logic [31:0] key, input logic [31:0] qty,
                                            input logic last);
    ckvt_out_t r;
    r.status         = st;
    r.position       = pos[POS_W-1:0];
    r.found_key      = key;
    r.found_quantity = qty;
    r.last_result    = last;
    return r;
  endfunction

  // works out the results of one item and applies it to the table copy
  task automatic predict_table(input ckvt_in_t it);
    int hit;
    int i;
    step_results.delete();
    hit = -1;
    // first entry whose key matches as a raw bit pattern
    for (i = 0; i < model_count && hit < 0; i++)
      if (model_key[i] == it.item_key) hit = i;
    case (it.opcode)
      OP_INSERT: begin
        if (model_count < DEPTH) begin
          model_key[model_count] = it.item_key;
          model_qty[model_count] = it.item_quantity;
          step_results.push_back(make_result(STAT_OK, model_count, it.item_key,
                                             it.item_quantity, 1'b1));
          model_count++;
        end else begin
          step_results.push_back(make_result(STAT_FULL, 0, '0, '0, 1'b1));
        end
      end
      OP_SEARCH, OP_DELETE: begin
        if (hit < 0) begin
          step_results.push_back(make_result(STAT_NOT_FOUND, 0, '0, '0, 1'b1));
        end else begin
          step_results.push_back(make_result(STAT_OK, hit, model_key[hit], model_qty[hit],
                                             1'b1));
          if (it.opcode == OP_DELETE) begin
            // close the gap: later entries move down one place
            for (i = hit; i + 1 < model_count; i++) begin
              model_key[i] = model_key[i+1];
              model_qty[i] = model_qty[i+1];
            end
            model_count--;
          end
        end
      end
      default: begin
        if (model_count == 0)
          step_results.push_back(make_result(STAT_EMPTY, 0, '0, '0, 1'b1));
        for (i = 0; i < model_count; i++)
          step_results.push_back(make_result(STAT_OK, i, model_key[i], model_qty[i],
                                             i + 1 == model_count));
      end
    endcase
  endtask

  // drives one item in bursts; returns in the time step of its acceptance
  task automatic send_item(input ckvt_in_t it, input logic fixed, input ckvt_out_t fixed_res);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      // mostly short bursts, now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    predict_table(it);
    if (fixed)
      pending_results.push_back(fixed_res);
    else
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endtask

  // sender holds off until the block has delivered everything owed
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    burst_left = 0;
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 3))
      0, 1: begin
        // a key already stored, so searches and deletes hit
        if (model_count > 0) return model_key[$urandom_range(0, model_count - 1)];
        return $urandom;
      end
      // narrow pool so duplicate keys pile up
      2:       return 32'hC0DE_0000 | $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // random items with the opcode mix given by the weights
  task automatic run_random(input int count, input int w_ins, input int w_srch,
                            input int w_del, input int w_list);
    ckvt_in_t it;
    int r;
    repeat (count) begin
      r = $urandom_range(0, w_ins + w_srch + w_del + w_list - 1);
      if (r < w_ins)                     it.opcode = OP_INSERT;
      else if (r < w_ins + w_srch)       it.opcode = OP_SEARCH;
      else if (r < w_ins + w_srch + w_del) it.opcode = OP_DELETE;
      else                               it.opcode = OP_LIST;
      it.item_key      = pick_key();
      it.item_quantity = $urandom;
      send_item(it, 1'b0, '0);
    end
  endtask

  function automatic stim_row_t plan_row(input row_kind_e kind, input ckvt_op_e op,
                                         input logic [31:0] key, input logic [31:0] qty,
                                         input logic fixed, input ckvt_out_t res);
    stim_row_t r;
    r.kind  = kind;
    r.op    = op;
    r.key   = key;
    r.qty   = qty;
    r.fixed = fixed;
    r.res   = res;
    return r;
  endfunction

  // every strobed result is checked against the oldest expectation
  always @(posedge clk) begin : check_results
    ckvt_out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 80'(out_item), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status)
          report_mismatch("status", 80'(out_item.status), 80'(want.status));
        if (out_item.position !== want.position)
          report_mismatch("position", 80'(out_item.position), 80'(want.position));
        if (out_item.found_key !== want.found_key)
          report_mismatch("found_key", 80'(out_item.found_key), 80'(want.found_key));
        if (out_item.found_quantity !== want.found_quantity)
          report_mismatch("found_quantity", 80'(out_item.found_quantity),
                          80'(want.found_quantity));
        if (out_item.last_result !== want.last_result)
          report_mismatch("last_result", 80'(out_item.last_result), 80'(want.last_result));
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    ckvt_in_t  it;

    // empty table: list reports empty, search and delete report not found
    directed_plan.push_back(plan_row(ROW_ITEM, OP_LIST, '0, '0, 1'b1,
                                     make_result(STAT_EMPTY, 0, '0, '0, 1'b1)));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_SEARCH, '0, '0, 1'b1,
                                     make_result(STAT_NOT_FOUND, 0, '0, '0, 1'b1)));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_DELETE, 32'h7FFF_FFFF, '0, 1'b1,
                                     make_result(STAT_NOT_FOUND, 0, '0, '0, 1'b1)));
    // extreme keys and quantities, then a duplicate key
    directed_plan.push_back(plan_row(ROW_ITEM, OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
        make_result(STAT_OK, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1)));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
        make_result(STAT_OK, 1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1)));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_INSERT, '0, '0, 1'b1,
        make_result(STAT_OK, 2, '0, '0, 1'b1)));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        make_result(STAT_OK, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1)));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_INSERT, 32'h7FFF_FFFF, 32'd5, 1'b1,
        make_result(STAT_OK, 4, 32'h7FFF_FFFF, 32'd5, 1'b1)));
    // duplicate key: the first match wins
    directed_plan.push_back(plan_row(ROW_ITEM, OP_SEARCH, 32'h7FFF_FFFF, '0, 1'b1,
        make_result(STAT_OK, 1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1)));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_SEARCH, 32'h1234_5678, '0, 1'b1,
        make_result(STAT_NOT_FOUND, 0, '0, '0, 1'b1)));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_LIST, '0, '0, 1'b0, '0));
    // delete at the head carries the removed entry
    directed_plan.push_back(plan_row(ROW_ITEM, OP_DELETE, 32'h8000_0000, '0, 1'b1,
        make_result(STAT_OK, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1)));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_SEARCH, 32'h7FFF_FFFF, '0, 1'b0, '0));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_DELETE, 32'hFFFF_FFFF, '0, 1'b0, '0));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_LIST, '0, '0, 1'b0, '0));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_DELETE, 32'h5555_5555, '0, 1'b1,
        make_result(STAT_NOT_FOUND, 0, '0, '0, 1'b1)));
    // fill to DEPTH, then insert into the full table
    directed_plan.push_back(plan_row(ROW_FILL, OP_INSERT, '0, '0, 1'b0, '0));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1,
        make_result(STAT_FULL, 0, '0, '0, 1'b1)));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_LIST, '0, '0, 1'b0, '0));
    // hit at the last position, then at the head of a nearly full table
    directed_plan.push_back(plan_row(ROW_ITEM, OP_DELETE, 32'h0001_003F, '0, 1'b0, '0));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_DELETE, 32'h7FFF_FFFF, '0, 1'b0, '0));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_SEARCH, 32'h7FFF_FFFF, '0, 1'b0, '0));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_INSERT, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0,
                                     '0));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_SEARCH, 32'h0001_003E, '0, 1'b0, '0));
    directed_plan.push_back(plan_row(ROW_ITEM, OP_LIST, '0, '0, 1'b0, '0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[n]) begin
      row = directed_plan[n];
      if (row.kind == ROW_FILL) begin
        // keys follow the position so the tail entries are known
        while (model_count < DEPTH) begin
          it.opcode        = OP_INSERT;
          it.item_key      = 32'h0001_0000 + model_count;
          it.item_quantity = $urandom;
          send_item(it, 1'b0, '0);
        end
      end else begin
        it.opcode        = row.op;
        it.item_key      = row.key;
        it.item_quantity = row.qty;
        send_item(it, row.fixed, row.res);
      end
    end
    wait_drained();

    // insert-heavy: climbs back to a full table
    run_random(60, 80, 8, 7, 5);
    wait_drained();
    // delete-heavy: drains toward empty, misses on an empty table
    run_random(60, 5, 10, 75, 10);
    wait_drained();
    run_random(45, 35, 25, 25, 15);

    wait_drained();
    // a delete may still be shifting after its result
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 80'(pending_results.size()), '0);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ckvt_pkg.sv
rtl/core/ckvt_dp.sv
rtl/core/ckvt_ctrl.sv
rtl/core/compacting_key_value_table_top.sv
verif/compacting_key_value_table_top_tb.sv
